@@ design/bgtr_pkg.sv @@
// ============================================================================
// bgtr_pkg
// Shared types and constants for the bitmap glyph text renderer.
// ============================================================================
`default_nettype none

package bgtr_pkg;

    // Request kinds carried on the command channel.
    localparam logic [1:0] REQ_DRAW   = 2'd0;
    localparam logic [1:0] REQ_CURSOR = 2'd1;
    localparam logic [1:0] REQ_FONT   = 2'd2;

    // Control characters handled without drawing.
    localparam logic [8:0] CODE_NEWLINE = 9'd10;
    localparam logic [8:0] CODE_TAB     = 9'd9;

    localparam logic [15:0] TAB_STEP   = 16'd4;
    localparam int          CELL_SHIFT = 3;

    // Configuration register indexes.
    localparam int          CFG_IDX_W        = 3;
    localparam logic [2:0]  CFG_FRAME_BASE   = 3'd0;
    localparam logic [2:0]  CFG_PITCH        = 3'd1;
    localparam logic [2:0]  CFG_TEXT_COLUMNS = 3'd2;
    localparam logic [2:0]  CFG_FG_COLOR     = 3'd3;
    localparam logic [2:0]  CFG_BG_COLOR     = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        CUR_NONE,
        CUR_ADVANCE,
        CUR_NEWLINE,
        CUR_TAB,
        CUR_LOAD
    } cur_op_t;

    typedef struct packed {
        cur_op_t     op;
        logic [15:0] row;
        logic [15:0] col;
    } cur_cmd_t;

endpackage

`default_nettype wire

@@ design/bgtr_cmd_if.sv @@
// ============================================================================
// bgtr_cmd_if
// Command channel: draw, cursor and glyph memory write requests.
// ============================================================================
`default_nettype none

interface bgtr_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [8:0]  char_code;
    logic [15:0] cursor_row;
    logic [15:0] cursor_col;
    logic [12:0] font_addr;
    logic [7:0]  font_byte;

    modport source (
        output valid, req_type, char_code, cursor_row, cursor_col, font_addr, font_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, char_code, cursor_row, cursor_col, font_addr, font_byte,
        output ready
    );
endinterface

`default_nettype wire

@@ design/bgtr_row_if.sv @@
// ============================================================================
// bgtr_row_if
// Result channel: one framebuffer address and eight pixel words per glyph row.
// ============================================================================
`default_nettype none

interface bgtr_row_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_word_addr;
    logic [31:0] pix0;
    logic [31:0] pix1;
    logic [31:0] pix2;
    logic [31:0] pix3;
    logic [31:0] pix4;
    logic [31:0] pix5;
    logic [31:0] pix6;
    logic [31:0] pix7;
    logic        last_row;

    modport source (
        output valid, pixel_word_addr, pix0, pix1, pix2, pix3, pix4, pix5, pix6, pix7,
               last_row,
        input  ready
    );
    modport sink (
        input  valid, pixel_word_addr, pix0, pix1, pix2, pix3, pix4, pix5, pix6, pix7,
               last_row,
        output ready
    );
endinterface

`default_nettype wire

@@ design/bgtr_cfg_if.sv @@
// ============================================================================
// bgtr_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
`default_nettype none

interface bgtr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

@@ design/bgtr_cursor.sv @@
// ============================================================================
// bgtr_cursor
// Text cursor: advance with line wrap, newline, tab and direct load.
// ============================================================================
`default_nettype none

module bgtr_cursor (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bgtr_pkg::cur_cmd_t cur_cmd,
    input  wire logic [12:0]       text_columns,
    output logic [15:0]            text_row,
    output logic [15:0]            text_col
);
    import bgtr_pkg::*;

    logic [15:0] row_reg;
    logic [15:0] row_next;
    logic [15:0] col_reg;
    logic [15:0] col_next;
    logic [15:0] col_inc;

    assign col_inc = col_reg + 16'd1;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        case (cur_cmd.op)
            CUR_ADVANCE:
            begin
                // A column at or past the line end wraps, so a tab overshoot wraps too.
                if (col_inc >= {3'b000, text_columns})
                begin
                    col_next = 16'd0;
                    row_next = row_reg + 16'd1;
                end
                else
                begin
                    col_next = col_inc;
                end
            end
            CUR_NEWLINE:
            begin
                col_next = 16'd0;
                row_next = row_reg + 16'd1;
            end
            CUR_TAB:
            begin
                col_next = col_reg + TAB_STEP;
            end
            CUR_LOAD:
            begin
                row_next = cur_cmd.row;
                col_next = cur_cmd.col;
            end
            default:
            begin
                row_next = row_reg;
                col_next = col_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= 16'd0;
            col_reg <= 16'd0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    assign text_row = row_reg;
    assign text_col = col_reg;

endmodule

`default_nettype wire

@@ design/bitmap_glyph_text_renderer_core.sv @@
// ============================================================================
// bitmap_glyph_text_renderer_core
// Text console renderer with a glyph memory and a row-by-row pixel output.
// ============================================================================
// Path: a draw passes address setup, the glyph memory read register and the
// output register. A drawn character holds the command side through accept,
// address multiply, then one glyph memory read per row through the single
// memory port, stalled by row back-pressure; any other request ends at accept.
// Reset: cursor, state machine and valid flags clear; configuration registers
// take their documented defaults. The glyph memory is not cleared.
`default_nettype none

module bitmap_glyph_text_renderer_core #(
    parameter int GLYPH_COUNT  = 512,
    parameter int GLYPH_HEIGHT = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bgtr_cmd_if.sink   cmd,
    bgtr_row_if.source rows,
    bgtr_cfg_if.sink   cfg
);
    import bgtr_pkg::*;

    // Memory geometry follows from the glyph count and height.
    localparam int DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(GLYPH_HEIGHT);
    localparam int WW    = (AW > 13) ? AW : 13;
    localparam logic [RW-1:0] LAST_ROW = RW'(GLYPH_HEIGHT - 1);
    localparam logic [11:0]   GC1      = 12'(GLYPH_COUNT);
    localparam logic [11:0]   GC2      = 12'(2 * GLYPH_COUNT);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are taken in any cycle; the user must
    // let them arrive only while the renderer is idle; it is not enforced here.
    // ------------------------------------------------------------------
    logic [29:0] frame_base_reg;
    logic [15:0] pitch_reg;
    logic [12:0] text_columns_reg;
    logic [31:0] fg_color_reg;
    logic [31:0] bg_color_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg   <= 30'd0;
            pitch_reg        <= 16'd1024;
            text_columns_reg <= 13'd128;
            fg_color_reg     <= 32'hFFFF_FFFF;
            bg_color_reg     <= 32'd0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FRAME_BASE:   frame_base_reg   <= cfg.data[29:0];
                CFG_PITCH:        pitch_reg        <= cfg.data[15:0];
                CFG_TEXT_COLUMNS: text_columns_reg <= cfg.data[12:0];
                CFG_FG_COLOR:     fg_color_reg     <= cfg.data;
                CFG_BG_COLOR:     bg_color_reg     <= cfg.data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request decode. Requests are taken only while the sequencer is idle;
    // results of an earlier character may still be draining.
    // ------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;

    logic cmd_fire;
    logic is_draw;
    logic is_glyph;

    assign cmd_fire = cmd.valid && cmd.ready;
    assign is_draw  = (cmd.req_type == REQ_DRAW);
    assign is_glyph = is_draw && (cmd.char_code != CODE_NEWLINE)
                              && (cmd.char_code != CODE_TAB);

    // The cursor module moves the cursor at the same edge that the request is
    // accepted; the draw setup below samples the cursor before that move.
    cur_cmd_t    cur_cmd;
    logic [15:0] text_row;
    logic [15:0] text_col;

    always_comb
    begin
        cur_cmd.op  = CUR_NONE;
        cur_cmd.row = cmd.cursor_row;
        cur_cmd.col = cmd.cursor_col;
        if (cmd_fire)
        begin
            case (cmd.req_type)
                REQ_DRAW:
                begin
                    if (cmd.char_code == CODE_NEWLINE)
                    begin
                        cur_cmd.op = CUR_NEWLINE;
                    end
                    else if (cmd.char_code == CODE_TAB)
                    begin
                        cur_cmd.op = CUR_TAB;
                    end
                    else
                    begin
                        cur_cmd.op = CUR_ADVANCE;
                    end
                end
                REQ_CURSOR: cur_cmd.op = CUR_LOAD;
                default:    cur_cmd.op = CUR_NONE;
            endcase
        end
    end

    bgtr_cursor u_cursor (
        .clk          (clk),
        .rst_n        (rst_n),
        .cur_cmd      (cur_cmd),
        .text_columns (text_columns_reg),
        .text_row     (text_row),
        .text_col     (text_col)
    );

    // Glyph number is the character code modulo the glyph count. A 9-bit code
    // is always below four times the smallest glyph count, so two conditional
    // subtractions are enough.
    logic [11:0] code_ext;
    logic [11:0] mod1;
    logic [11:0] mod2;
    logic [AW-1:0] glyph_base;

    assign code_ext   = {3'b000, cmd.char_code};
    assign mod1       = (code_ext >= GC2) ? (code_ext - GC2) : code_ext;
    assign mod2       = (mod1 >= GC1) ? (mod1 - GC1) : mod1;
    assign glyph_base = AW'(mod2 * GLYPH_HEIGHT);

    // ------------------------------------------------------------------
    // Draw setup registers. The first address is built in two steps: the
    // column offset and the line index at accept, then one multiply by the
    // pitch in the setup cycle. Later rows add the pitch.
    // ------------------------------------------------------------------
    logic [AW-1:0] glyph_base_reg;
    logic [31:0]   line0_reg;
    logic [31:0]   cell_base_reg;
    logic [31:0]   addr_acc_reg;
    logic [31:0]   addr_acc_next;
    logic [RW-1:0] row_cnt_reg;
    logic [RW-1:0] row_cnt_next;

    always_ff @(posedge clk)
    begin
        if (cmd_fire && is_glyph)
        begin
            glyph_base_reg <= glyph_base;
            line0_reg      <= 32'(text_row * GLYPH_HEIGHT);
            cell_base_reg  <= {2'b00, frame_base_reg} + {13'd0, text_col, 3'b000};
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: idle, address setup, then one glyph memory read per row.
    // ------------------------------------------------------------------
    logic issue;
    logic q_move;
    logic q_valid_reg;
    logic q_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    // The read stage may refill only when its current row is leaving.
    assign q_move = q_valid_reg && (!out_valid_reg || rows.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && is_glyph)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (issue && (row_cnt_reg == LAST_ROW))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.ready     = 1'b0;
        issue         = 1'b0;
        row_cnt_next  = row_cnt_reg;
        addr_acc_next = addr_acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            ST_SETUP:
            begin
                row_cnt_next  = '0;
                addr_acc_next = cell_base_reg + 32'(line0_reg * pitch_reg);
            end
            ST_EMIT:
            begin
                issue = !q_valid_reg || q_move;
                if (issue)
                begin
                    row_cnt_next  = row_cnt_reg + RW'(1);
                    addr_acc_next = addr_acc_reg + {16'd0, pitch_reg};
                end
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            row_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_acc_reg <= addr_acc_next;
    end

    // ------------------------------------------------------------------
    // Glyph memory: one port, written by glyph requests while idle and read
    // by the sequencer. Read data is registered and holds until the next read.
    // ------------------------------------------------------------------
    logic [7:0]    glyph_mem [DEPTH];
    logic [7:0]    mem_q_reg;
    logic [WW-1:0] font_addr_ext;
    logic          font_we;
    logic [AW-1:0] rd_addr;

    assign font_addr_ext = WW'(cmd.font_addr);
    assign font_we       = cmd_fire && (cmd.req_type == REQ_FONT)
                           && (32'(cmd.font_addr) < 32'(DEPTH));
    assign rd_addr       = glyph_base_reg + AW'(row_cnt_reg);

    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            glyph_mem[font_addr_ext[AW-1:0]] <= cmd.font_byte;
        end
        if (issue)
        begin
            mem_q_reg <= glyph_mem[rd_addr];
        end
    end

    // Side data that travels with the row being read.
    logic [31:0] q_addr_reg;
    logic        q_last_reg;

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            q_addr_reg <= addr_acc_reg;
            q_last_reg <= (row_cnt_reg == LAST_ROW);
        end
    end

    always_comb
    begin
        q_valid_next = q_valid_reg;
        if (issue)
        begin
            q_valid_next = 1'b1;
        end
        else if (q_move)
        begin
            q_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output register: expands the glyph byte into eight pixel words. It
    // decouples the row consumer from the memory read stage.
    // ------------------------------------------------------------------
    logic [31:0] out_addr_reg;
    logic [31:0] out_pix_reg [8];
    logic        out_last_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (rows.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_move)
        begin
            out_addr_reg <= q_addr_reg;
            out_last_reg <= q_last_reg;
            for (int k = 0; k < 8; k++)
            begin
                // Glyph bit 7 is the leftmost pixel.
                out_pix_reg[k] <= mem_q_reg[7 - k] ? fg_color_reg : bg_color_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            q_valid_reg   <= q_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rows.valid           = out_valid_reg;
    assign rows.pixel_word_addr = out_addr_reg;
    assign rows.pix0            = out_pix_reg[0];
    assign rows.pix1            = out_pix_reg[1];
    assign rows.pix2            = out_pix_reg[2];
    assign rows.pix3            = out_pix_reg[3];
    assign rows.pix4            = out_pix_reg[4];
    assign rows.pix5            = out_pix_reg[5];
    assign rows.pix6            = out_pix_reg[6];
    assign rows.pix7            = out_pix_reg[7];
    assign rows.last_row        = out_last_reg;

`ifndef SYNTHESIS
    // A drawn character always goes through the address setup cycle.
    a_draw_enters_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && is_glyph) |=> (state_reg == ST_SETUP))
        else $error("draw request did not start address setup");

    // Setup hands over to the row reads with the row counter at zero.
    a_setup_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SETUP) |=> ((state_reg == ST_EMIT) && (row_cnt_reg == '0)))
        else $error("row reads did not start from the first glyph row");

    // The read of the final glyph row ends the character.
    a_last_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && (row_cnt_reg == LAST_ROW)) |=> (state_reg == ST_IDLE) && q_last_reg)
        else $error("final glyph row read did not end the character");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ============================================================================
// tb_top
// Self-checking bench for the text console glyph renderer. A scoreboard class
// tracks the glyph memory, the text cursor and the register settings, and
// computes the sixteen rows that every drawn character must produce. Plain
// tasks drive the command and configuration channels; a separate process
// throttles the row channel.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
    import bgtr_pkg::*;

    // ------------------------------------------------------------------------
    // Bench constants.
    // ------------------------------------------------------------------------
    localparam int GLYPHS       = 512;
    localparam int GLYPH_ROWS   = 16;
    localparam int RANDOM_ITEMS = 120;
    // Cycles to let pass once the last row is back before touching registers.
    // A draw occupies the block through accept, address setup and the row
    // reads, and then the output stage.
    localparam int SETTLE_CYCLES = 24;
    localparam int TAIL_CYCLES   = 40;
    // Cycles without any accepted request on any channel before giving up.
    // The longest legal quiet stretch is the receiver hold-off.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;

    // The request kind the block must ignore has no name in the package.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // One command channel request as the bench builds it.
    typedef struct {
        logic [1:0]  kind;
        logic [8:0]  code;
        logic [15:0] row;
        logic [15:0] col;
        logic [12:0] faddr;
        logic [7:0]  fbyte;
    } console_req_t;

    // One glyph row on the result channel.
    typedef struct packed {
        logic [31:0]       addr;
        logic [7:0][31:0]  pix;
        logic              last;
    } glyph_row_t;

    // ------------------------------------------------------------------------
    // Scoreboard: glyph memory, cursor and registers, plus the queue of rows
    // that are still owed by the block.
    // ------------------------------------------------------------------------
    class raster_scoreboard;
        logic [7:0]  font_mem [GLYPHS * GLYPH_ROWS];
        logic [15:0] cur_row;
        logic [15:0] cur_col;
        logic [29:0] frame_base;
        logic [15:0] pitch;
        logic [12:0] columns;
        logic [31:0] fg;
        logic [31:0] bg;
        glyph_row_t  owed_rows [$];
        int          mismatches;
        int          rows_seen;
        int          draws;

        function new();
            cur_row    = '0;
            cur_col    = '0;
            frame_base = '0;
            pitch      = 16'd1024;
            columns    = 13'd128;
            fg         = 32'hFFFF_FFFF;
            bg         = 32'h0000_0000;
            mismatches = 0;
            rows_seen  = 0;
            draws      = 0;
        endfunction

        function int pending();
            return owed_rows.size();
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                CFG_FRAME_BASE:   frame_base = data[29:0];
                CFG_PITCH:        pitch      = data[15:0];
                CFG_TEXT_COLUMNS: columns    = data[12:0];
                CFG_FG_COLOR:     fg         = data;
                CFG_BG_COLOR:     bg         = data;
                default:          ;
            endcase
        endfunction

        // Called once per accepted command request, in acceptance order.
        function void note_request(console_req_t r);
            glyph_row_t  e;
            logic [31:0] line;
            logic [12:0] idx;
            logic [7:0]  bits;
            int          i;
            int          k;
            case (r.kind)
                REQ_DRAW:
                begin
                    if (r.code == CODE_NEWLINE)
                    begin
                        cur_row = cur_row + 16'd1;
                        cur_col = '0;
                    end
                    else if (r.code == CODE_TAB)
                    begin
                        // No wrap test here; an overshoot wraps on the next draw.
                        cur_col = cur_col + TAB_STEP;
                    end
                    else
                    begin
                        draws++;
                        for (i = 0; i < GLYPH_ROWS; i++)
                        begin
                            // All terms are 32 bits wide so the sum wraps mod 2^32.
                            line   = ({16'd0, cur_row} * GLYPH_ROWS) + i;
                            e.addr = {2'b00, frame_base} + ({16'd0, cur_col} << CELL_SHIFT)
                                   + line * {16'd0, pitch};
                            idx    = 13'(r.code * GLYPH_ROWS + i);
                            bits   = font_mem[idx];
                            for (k = 0; k < 8; k++)
                                e.pix[k] = bits[7 - k] ? fg : bg;
                            e.last = (i == GLYPH_ROWS - 1);
                            owed_rows.push_back(e);
                        end
                        cur_col = cur_col + 16'd1;
                        if (cur_col >= {3'b000, columns})
                        begin
                            cur_col = '0;
                            cur_row = cur_row + 16'd1;
                        end
                    end
                end
                REQ_CURSOR:
                begin
                    cur_row = r.row;
                    cur_col = r.col;
                end
                REQ_FONT:
                    font_mem[r.faddr] = r.fbyte;
                default:
                    ;
            endcase
        endfunction

        task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("[%0t] MISMATCH row %0d %s: got %h, expected %h",
                     $realtime, rows_seen, what, got, want);
        endtask

        task check_row(glyph_row_t got);
            glyph_row_t want;
            int         k;
            if (owed_rows.size() == 0)
            begin
                flag_mismatch("unexpected row, address", got.addr, 32'h0);
            end
            else
            begin
                want = owed_rows.pop_front();
                if (got.addr !== want.addr)
                    flag_mismatch("pixel_word_addr", got.addr, want.addr);
                for (k = 0; k < 8; k++)
                    if (got.pix[k] !== want.pix[k])
                        flag_mismatch($sformatf("pix%0d", k), got.pix[k], want.pix[k]);
                if (got.last !== want.last)
                    flag_mismatch("last_row", {31'd0, got.last}, {31'd0, want.last});
            end
            rows_seen++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block itself.
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bgtr_cmd_if cmd ();
    bgtr_row_if rows ();
    bgtr_cfg_if cfg ();

    bitmap_glyph_text_renderer_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rows  (rows),
        .cfg   (cfg)
    );

    raster_scoreboard sb = new();

    // Idle percentages for each side; the stimulus drops them to zero for a
    // stretch so that back-to-back traffic is covered too.
    int tx_idle_pct = 26;
    int rx_idle_pct = 26;
    // A request for a long receiver hold-off, picked up by the receiver process.
    int rx_hold_req = 0;

    int items_sent   = 0;
    int config_count = 0;

    // Which rows of each glyph have been written, and the glyphs that are
    // complete and may therefore be drawn. Control codes are never drawable.
    logic [15:0] rows_loaded [GLYPHS];
    bit          is_drawable [GLYPHS];
    logic [8:0]  drawable_codes [$];

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure on the row channel, plus the long
    // hold-off that fills the block up and stalls its command side.
    // ------------------------------------------------------------------------
    int hold_left = 0;

    always @(negedge clk)
    begin
        if (rx_hold_req > 0)
        begin
            hold_left   = rx_hold_req;
            rx_hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rows.ready <= 1'b0;
        end
        else
        begin
            rows.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Row monitor: every accepted row is compared with the oldest owed row.
    always @(posedge clk)
    begin
        glyph_row_t got;
        if (rst_n && rows.valid && rows.ready)
        begin
            got.addr   = rows.pixel_word_addr;
            got.pix[0] = rows.pix0;
            got.pix[1] = rows.pix1;
            got.pix[2] = rows.pix2;
            got.pix[3] = rows.pix3;
            got.pix[4] = rows.pix4;
            got.pix[5] = rows.pix5;
            got.pix[6] = rows.pix6;
            got.pix[7] = rows.pix7;
            got.last   = rows.last_row;
            sb.check_row(got);
        end
    end

    // Watchdog: a run that stops moving on every channel is a hang.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd.valid && cmd.ready) || (rows.valid && rows.ready)
                || (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired after %0d idle cycles, %0d rows still owed",
                         quiet_cycles, sb.pending());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request builders. Fields a request does not use carry random values so
    // that every bit of every field toggles.
    // ------------------------------------------------------------------------
    function automatic console_req_t noise_req();
        console_req_t r;
        r.kind  = REQ_UNUSED;
        r.code  = 9'($urandom);
        r.row   = 16'($urandom);
        r.col   = 16'($urandom);
        r.faddr = 13'($urandom);
        r.fbyte = 8'($urandom);
        return r;
    endfunction

    function automatic console_req_t draw_req(logic [8:0] code);
        console_req_t r;
        r      = noise_req();
        r.kind = REQ_DRAW;
        r.code = code;
        return r;
    endfunction

    function automatic console_req_t cursor_req(logic [15:0] row, logic [15:0] col);
        console_req_t r;
        r      = noise_req();
        r.kind = REQ_CURSOR;
        r.row  = row;
        r.col  = col;
        return r;
    endfunction

    // Builds a glyph memory write and records which glyph row it fills.
    function automatic console_req_t font_req(logic [12:0] addr, logic [7:0] data);
        console_req_t r;
        logic [8:0]   g;
        r       = noise_req();
        r.kind  = REQ_FONT;
        r.faddr = addr;
        r.fbyte = data;
        g       = addr[12:4];
        rows_loaded[g][addr[3:0]] = 1'b1;
        if (rows_loaded[g] == 16'hFFFF && !is_drawable[g]
            && g != CODE_NEWLINE && g != CODE_TAB)
        begin
            is_drawable[g] = 1'b1;
            drawable_codes.push_back(g);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers. Every task starts and ends on a falling edge, and assigns each
    // handshake signal at most once per falling edge.
    // ------------------------------------------------------------------------
    task automatic send_req(input console_req_t r);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.req_type   <= r.kind;
        cmd.char_code  <= r.code;
        cmd.cursor_row <= r.row;
        cmd.cursor_col <= r.col;
        cmd.font_addr  <= r.faddr;
        cmd.font_byte  <= r.fbyte;
        do
            @(posedge clk);
        while (!cmd.ready);
        sb.note_request(r);
        if (r.kind != REQ_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    // Writes all sixteen rows of one glyph; a negative fill means random bytes.
    task automatic load_glyph(input logic [8:0] code, input int fill);
        int i;
        for (i = 0; i < GLYPH_ROWS; i++)
            send_req(font_req(13'(code * GLYPH_ROWS + i),
                              (fill < 0) ? 8'($urandom) : 8'(fill)));
    endtask

    // Stops offering requests and waits until every owed row is back, then a
    // little longer in case a request without results is still in flight.
    task automatic wait_drained(input int extra);
        cmd.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    // Writes all five registers, only ever with the block idle.
    task automatic apply_config(input logic [29:0] base, input logic [15:0] pitch,
                                input logic [12:0] cols, input logic [31:0] fg,
                                input logic [31:0] bg);
        logic [2:0]  idxs [5];
        logic [31:0] vals [5];
        int          j;
        idxs = '{CFG_FRAME_BASE, CFG_PITCH, CFG_TEXT_COLUMNS, CFG_FG_COLOR, CFG_BG_COLOR};
        vals = '{{2'b00, base}, {16'd0, pitch}, {19'd0, cols}, fg, bg};
        wait_drained(SETTLE_CYCLES);
        for (j = 0; j < 5; j++)
        begin
            cfg.valid <= 1'b1;
            cfg.index <= idxs[j];
            cfg.data  <= vals[j];
            do
                @(posedge clk);
            while (!cfg.ready);
            sb.write_reg(idxs[j], vals[j]);
            @(negedge clk);
        end
        cfg.valid <= 1'b0;
        config_count++;
    endtask

    task automatic random_config();
        apply_config(30'($urandom), 16'($urandom_range(1, 65535)),
                     13'($urandom_range(1, 160)), $urandom, $urandom);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin
        int          random_start;
        int          pick;
        int          g;
        bit          pressure_done;
        bit          cfg_a_done;
        bit          cfg_b_done;
        bit          cfg_c_done;
        console_req_t r;

        pressure_done = 1'b0;
        cfg_a_done    = 1'b0;
        cfg_b_done    = 1'b0;
        cfg_c_done    = 1'b0;
        for (g = 0; g < GLYPHS; g++)
        begin
            rows_loaded[g] = '0;
            is_drawable[g] = 1'b0;
        end

        // Every input is known from time zero.
        rst_n          = 1'b0;
        cmd.valid      = 1'b0;
        cmd.req_type   = REQ_DRAW;
        cmd.char_code  = '0;
        cmd.cursor_row = '0;
        cmd.cursor_col = '0;
        cmd.font_addr  = '0;
        cmd.font_byte  = '0;
        rows.ready     = 1'b0;
        cfg.valid      = 1'b0;
        cfg.index      = CFG_FRAME_BASE;
        cfg.data       = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Glyphs for the directed part: all clear, all set, the two ends of
        // the code range and a couple of random patterns.
        load_glyph(9'd0, 8'h00);
        load_glyph(9'd511, 8'hFF);
        load_glyph(9'd65, -1);
        load_glyph(9'd255, 8'hA5);
        load_glyph(9'd256, -1);

        // Directed part under the reset register values. Newline and tab only
        // move the cursor; the second draw after column 126 hits the line end.
        send_req(draw_req(9'd65));
        send_req(draw_req(9'd0));
        send_req(draw_req(9'd511));
        send_req(draw_req(CODE_TAB));
        send_req(draw_req(9'd256));
        send_req(draw_req(CODE_NEWLINE));
        send_req(draw_req(9'd255));
        send_req(cursor_req(16'd5, 16'd126));
        send_req(draw_req(9'd65));
        send_req(draw_req(9'd65));
        // The unused request kind must be ignored.
        r = noise_req();
        send_req(r);
        // Cursor at the far corner: the column and then the row wrap at 16 bits.
        send_req(cursor_req(16'hFFFF, 16'hFFFF));
        send_req(draw_req(9'd511));
        send_req(draw_req(CODE_NEWLINE));
        send_req(draw_req(9'd0));

        // Largest base, pitch and row, so the address wraps modulo 2^32. A
        // narrow line lets a tab overshoot the end; the next draw still wraps.
        apply_config(30'h3FFF_FFFF, 16'hFFFF, 13'd3, 32'h0000_0000, 32'hFFFF_FFFF);
        send_req(cursor_req(16'hFFFF, 16'd1));
        send_req(draw_req(9'd65));
        send_req(draw_req(CODE_TAB));
        send_req(draw_req(9'd256));
        send_req(draw_req(9'd255));

        // Zero column count: the column wraps after every character.
        apply_config(30'd0, 16'd1, 13'd0, $urandom, $urandom);
        send_req(cursor_req(16'd0, 16'd0));
        send_req(draw_req(9'd65));
        send_req(draw_req(9'd256));
        send_req(draw_req(CODE_TAB));
        send_req(draw_req(9'd0));

        random_config();

        // Random part: mostly draws with random cursor moves in between, plus glyph
        // loads followed by a draw, stray glyph writes and ignored requests.
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (!pressure_done && items_sent - random_start >= 15)
            begin
                // Hold the row channel off while draws keep coming, so the
                // block fills and stops accepting commands.
                pressure_done = 1'b1;
                rx_hold_req   = HOLD_OFF_CYCLES;
                repeat (10)
                    send_req(draw_req(drawable_codes[$urandom_range(0,
                                                      drawable_codes.size() - 1)]));
            end
            if (!cfg_a_done && items_sent - random_start >= 40)
            begin
                cfg_a_done = 1'b1;
                random_config();
            end
            if (items_sent - random_start >= 50 && items_sent - random_start < 85)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else
            begin
                tx_idle_pct = 26;
                rx_idle_pct = 26;
            end
            if (!cfg_b_done && items_sent - random_start >= 78)
            begin
                // Widest line, smallest stride, default colors.
                cfg_b_done = 1'b1;
                apply_config(30'd0, 16'd1, 13'd8191, 32'hFFFF_FFFF, 32'h0000_0000);
            end
            if (!cfg_c_done && items_sent - random_start >= 105)
            begin
                cfg_c_done = 1'b1;
                random_config();
            end

            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                g = $urandom_range(0, GLYPHS - 1);
                load_glyph(9'(g), -1);
                if (is_drawable[g])
                    send_req(draw_req(9'(g)));
            end
            else if (pick < 22)
            begin
                send_req(font_req(13'($urandom), 8'($urandom)));
            end
            else if (pick < 68)
            begin
                send_req(draw_req(drawable_codes[$urandom_range(0,
                                                  drawable_codes.size() - 1)]));
            end
            else if (pick < 78)
            begin
                send_req(draw_req(($urandom_range(0, 1) != 0) ? CODE_NEWLINE : CODE_TAB));
            end
            else if (pick < 94)
            begin
                if ($urandom_range(0, 99) < 20)
                    send_req(cursor_req(16'($urandom), 16'($urandom)));
                else
                    send_req(cursor_req(16'($urandom_range(0, 40)),
                                        16'($urandom_range(0, 150))));
            end
            else
            begin
                send_req(noise_req());
            end
        end

        // Let every owed row arrive, then watch a little longer for strays.
        wait_drained(TAIL_CYCLES);

        $display("Run covered %0d requests, %0d character draws and %0d glyph rows",
                 items_sent, sb.draws, sb.rows_seen);
        $display("over %0d register settings, with a long row hold-off and drain pauses",
                 config_count);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("%0d mismatches, %0d rows still owed", sb.mismatches, sb.pending());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/bgtr_pkg.sv
design/bgtr_cmd_if.sv
design/bgtr_row_if.sv
design/bgtr_cfg_if.sv
design/bgtr_cursor.sv
design/bitmap_glyph_text_renderer_core.sv
tb/sv/tb_top.sv
